// ----- rtl/oets_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_pkg: shared types and constants of the transposition sorter
// element width, default block depth, queue depth, queue entry and sorter
// states
// ----------------------------------------------------------------------------
package oets_pkg;

	localparam int DATA_W             = 32;
	localparam int DEFAULT_SORT_DEPTH = 64;
	localparam int QUEUE_DEPTH        = 4;

	// one queued element, tagged with whether it closes its block
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     ends;
	} item_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} sort_state_t;

endpackage

// ----- rtl/oets_intake.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_intake: front end of the sorter
// takes one element per transfer, marks the element that closes a block
// (last flag or store full) and pushes it into the queue
// ----------------------------------------------------------------------------
module oets_intake #(
	parameter int SORT_DEPTH = oets_pkg::DEFAULT_SORT_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [oets_pkg::DATA_W-1:0]  value,
	input  logic                                last,
	input  logic                                queue_full,
	output logic                                busy,
	output logic                                push,
	output oets_pkg::item_t                     push_item
);
	import oets_pkg::*;

	localparam int CNT_W = $clog2(SORT_DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_inc;
	logic             ends;

	assign busy      = queue_full;
	assign push      = start && !queue_full;
	assign count_inc = count_q + 1'b1;
	assign ends      = last || (count_inc == CNT_W'(SORT_DEPTH));

	assign push_item.value = value;
	assign push_item.ends  = ends;

	// elements taken so far in the open block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= ends ? '0 : count_inc;
		end
	end

endmodule

// ----- rtl/oets_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_queue: short fifo between intake and sorter
// lets the front keep taking elements while the sorter is busy
// ----------------------------------------------------------------------------
module oets_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  oets_pkg::item_t push_item,
	input  logic            pop,
	output oets_pkg::item_t pop_item,
	output logic            full,
	output logic            empty
);
	import oets_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	item_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (level_q == LVL_W'(QUEUE_DEPTH));
	assign empty    = (level_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/oets_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_sorter: back end of the sorter
// loads a block into a row of cells, runs one odd plus one even
// compare-exchange phase per cycle, then shifts the sorted block out
// ----------------------------------------------------------------------------
module oets_sorter #(
	parameter int SORT_DEPTH = oets_pkg::DEFAULT_SORT_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                queue_empty,
	input  oets_pkg::item_t                     pop_item,
	output logic                                pop,
	output logic                                strobe,
	output logic signed [oets_pkg::DATA_W-1:0]  sorted_value,
	output logic                                last_out
);
	import oets_pkg::*;

	localparam int CNT_W = $clog2(SORT_DEPTH + 1);
	localparam int IDX_W = $clog2(SORT_DEPTH);

	sort_state_t              state_q;
	sort_state_t              state_d;
	logic signed [DATA_W-1:0] cell_q  [SORT_DEPTH];
	logic signed [DATA_W-1:0] odd_ph  [SORT_DEPTH];
	logic signed [DATA_W-1:0] even_ph [SORT_DEPTH];
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         step_q;
	logic [CNT_W-1:0]         cnt_last;
	logic                     step_last;

	assign cnt_last  = cnt_q - 1'b1;
	assign step_last = (step_q == cnt_last);

	// odd pairs then even pairs, only inside the loaded block
	always_comb begin
		odd_ph = cell_q;
		for (int j = 1; j < SORT_DEPTH; j += 2) begin
			if ((CNT_W'(j) < cnt_q) && (cell_q[j] < cell_q[j-1])) begin
				odd_ph[j]   = cell_q[j-1];
				odd_ph[j-1] = cell_q[j];
			end
		end
		even_ph = odd_ph;
		for (int j = 2; j < SORT_DEPTH; j += 2) begin
			if ((CNT_W'(j) < cnt_q) && (odd_ph[j] < odd_ph[j-1])) begin
				even_ph[j]   = odd_ph[j-1];
				even_ph[j-1] = odd_ph[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		strobe   = 1'b0;
		last_out = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				pop = !queue_empty;
				if (!queue_empty && pop_item.ends) begin
					state_d = ST_SORT;
				end
			end
			ST_SORT: begin
				if (step_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				strobe   = 1'b1;
				last_out = step_last;
				if (step_last) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	assign sorted_value = cell_q[0];

	// block size and round / output counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			step_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					step_q <= '0;
					if (pop) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SORT: begin
					step_q <= step_last ? '0 : step_q + 1'b1;
				end
				ST_EMIT: begin
					step_q <= step_q + 1'b1;
					if (step_last) begin
						cnt_q <= '0;
					end
				end
				default: begin
					step_q <= '0;
				end
			endcase
		end
	end

	// cell row
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (pop) begin
					cell_q[cnt_q[IDX_W-1:0]] <= pop_item.value;
				end
			end
			ST_SORT: begin
				cell_q <= even_ph;
			end
			ST_EMIT: begin
				for (int i = 0; i < SORT_DEPTH - 1; i++) begin
					cell_q[i] <= cell_q[i+1];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/odd_even_transposition_sort.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_even_transposition_sort: block sorter for signed 32-bit values
// elements in one per transfer, sorted block out one per cycle
// ----------------------------------------------------------------------------
// usage
//  - input channel: an element transfers on a rising edge with start high and
//    busy low; value carries the element, last closes the block. the element
//    that fills SORT_DEPTH entries closes the block as well
//  - output channel: each sorted element shows on sorted_value for exactly
//    one cycle with strobe high; last_out marks the final one. results come
//    out on consecutive cycles and the receiver cannot hold them off
//  - intake pushes elements into a four-entry queue; busy is high only while
//    that queue is full, so elements keep arriving while a block sorts
//  - the sorter pops one element per cycle, while the queue is not empty, into
//    a row of cells, then runs n rounds for an n-element block, one odd phase
//    and one even phase per cycle, then shifts the block out
//  - a block passes through the sorter as load, rounds and output in turn,
//    set by the single cell-row load port and one round a cycle; the first
//    result shows once the last round is done
//  - reset clears the queue, counters and sorter state; no block is open
// ----------------------------------------------------------------------------
module odd_even_transposition_sort #(
	parameter int SORT_DEPTH = oets_pkg::DEFAULT_SORT_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [oets_pkg::DATA_W-1:0]  value,
	input  logic                                last,
	output logic                                strobe,
	output logic signed [oets_pkg::DATA_W-1:0]  sorted_value,
	output logic                                last_out
);
	import oets_pkg::*;

	// queue links between front and back
	item_t push_item;
	item_t pop_item;
	logic  push;
	logic  pop;
	logic  queue_full;
	logic  queue_empty;

	// front: classify each element and queue it
	oets_intake #(
		.SORT_DEPTH (SORT_DEPTH)
	) u_intake (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.last       (last),
		.queue_full (queue_full),
		.busy       (busy),
		.push       (push),
		.push_item  (push_item)
	);

	oets_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	// back: load, sort and emit whole blocks
	oets_sorter #(
		.SORT_DEPTH (SORT_DEPTH)
	) u_sorter (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_empty  (queue_empty),
		.pop_item     (pop_item),
		.pop          (pop),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.last_out     (last_out)
	);

endmodule

// ----- rtl/oets_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_checker: port-level checks of the sorter
// output bursts are unbroken, ascending and end with last_out
// ----------------------------------------------------------------------------
module oets_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                strobe,
	input logic signed [oets_pkg::DATA_W-1:0]  sorted_value,
	input logic                                last_out
);
	import oets_pkg::*;

	// last_out only on a result cycle
	a_last_needs_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_out |-> strobe)
		else $error("last_out without strobe");

	// a block leaves without gaps
	a_burst_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_out |=> strobe)
		else $error("gap inside an output block");

	// the back end reloads after a block, so no result right after last_out
	a_gap_after_block: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_out |=> !strobe)
		else $error("result right after the end of a block");

	// results of a block come out in ascending order
	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_out |=> sorted_value >= $past(sorted_value))
		else $error("output block not ascending");

endmodule

bind odd_even_transposition_sort oets_checker u_oets_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.strobe       (strobe),
	.sorted_value (sorted_value),
	.last_out     (last_out)
);

// ----- test/oets_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oets_result_checker: scoreboard for the transposition sorter
// collects accepted elements into blocks, sorts each closed block the same
// way the hardware does and compares every strobed result in order
// ----------------------------------------------------------------------------
module oets_result_checker #(
	parameter int SORT_DEPTH = oets_pkg::DEFAULT_SORT_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic signed [oets_pkg::DATA_W-1:0]  value,
	input  logic                                last,
	input  logic                                strobe,
	input  logic signed [oets_pkg::DATA_W-1:0]  sorted_value,
	input  logic                                last_out,
	output int                                  mismatch_count,
	output int                                  results_owed
);
	import oets_pkg::*;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} sorted_elem_t;

	logic signed [DATA_W-1:0] block_cells [SORT_DEPTH];
	int                       block_fill = 0;
	int                       errors     = 0;
	sorted_elem_t             sorted_q [$];
	sorted_elem_t             head;

	// odd-even transposition over the open block, then queue it in order
	task automatic sort_and_queue_block();
		int                       n;
		int                       j;
		logic signed [DATA_W-1:0] tmp;
		sorted_elem_t             elem;
		n = block_fill;
		for (int r = 0; r < n; r++) begin
			for (j = 1; j < n; j += 2) begin
				if (block_cells[j] < block_cells[j-1]) begin
					tmp              = block_cells[j];
					block_cells[j]   = block_cells[j-1];
					block_cells[j-1] = tmp;
				end
			end
			for (j = 2; j < n; j += 2) begin
				if (block_cells[j] < block_cells[j-1]) begin
					tmp              = block_cells[j];
					block_cells[j]   = block_cells[j-1];
					block_cells[j-1] = tmp;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			elem.value = block_cells[k];
			elem.last  = (k == n - 1);
			sorted_q.push_back(elem);
		end
		block_fill = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_fill = 0;
			sorted_q.delete();
			mismatch_count <= errors;
			results_owed   <= 0;
		end else begin
			if (strobe) begin
				if (sorted_q.size() == 0) begin
					$error("sorted_value: expected none, actual %0d", sorted_value);
					errors++;
				end else begin
					head = sorted_q.pop_front();
					if (sorted_value !== head.value) begin
						$error("sorted_value: expected %0d, actual %0d", head.value, sorted_value);
						errors++;
					end
					if (last_out !== head.last) begin
						$error("last_out: expected %0b, actual %0b", head.last, last_out);
						errors++;
					end
				end
			end
			// a full store closes the block even without last
			if (start && !busy) begin
				block_cells[block_fill] = value;
				block_fill++;
				if (last || block_fill == SORT_DEPTH)
					sort_and_queue_block();
			end
			mismatch_count <= errors;
			results_owed   <= sorted_q.size();
		end
	end

endmodule

// ----- test/odd_even_transposition_sort_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odd_even_transposition_sort_tb: top of the sorter testbench
// drives blocks of signed elements with random gaps, directed extremes
// first, then random blocks including one that fills the store; the
// checker beside the block predicts and compares every sorted result
// ----------------------------------------------------------------------------
module odd_even_transposition_sort_tb;
	import oets_pkg::*;

	localparam int SORT_DEPTH   = DEFAULT_SORT_DEPTH;
	localparam int RANDOM_ITEMS = 110;
	// drain wait covers a full-size block loading, sorting and leaving, plus slack
	localparam int DRAIN_CYCLES = 3 * SORT_DEPTH + 20;

	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	logic                     clk    = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start  = 1'b0;
	logic signed [DATA_W-1:0] value  = '0;
	logic                     last   = 1'b0;
	logic                     busy;
	logic                     strobe;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     last_out;
	int                       mismatch_count;
	int                       results_owed;

	odd_even_transposition_sort #(
		.SORT_DEPTH(SORT_DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.last        (last),
		.strobe      (strobe),
		.sorted_value(sorted_value),
		.last_out    (last_out)
	);

	// watches both channels, owns the prediction
	oets_result_checker #(
		.SORT_DEPTH(SORT_DEPTH)
	) result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.value         (value),
		.last          (last),
		.strobe        (strobe),
		.sorted_value  (sorted_value),
		.last_out      (last_out),
		.mismatch_count(mismatch_count),
		.results_owed  (results_owed)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the sorter hangs
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// one element transfer: hold start until the edge that sees busy low,
	// then idle for gap cycles; with gap zero start stays high for the next
	task automatic send_element(input logic signed [DATA_W-1:0] v, input logic l,
			input int gap);
		start <= 1'b1;
		value <= v;
		last  <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// mostly back to back or short gaps, now and then a long one
	function automatic int pick_gap(input bit burst);
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// full-range values with extremes and a cluster of small ones for ties
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2, 3:    return DATA_W'(int'($urandom_range(0, 6)) - 3);
			default: return $urandom;
		endcase
	endfunction

	// sender pause until the checker has nothing outstanding; start drops
	// so no element repeats, and the first edge lets the checker's count
	// catch up with the latest transfer
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
	endtask

	initial begin
		int  sent;
		int  blk;
		int  size;
		bit  burst;
		bit  fill_block;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-element blocks at both extremes
		send_element(VAL_MAX, 1'b1, pick_gap(0));
		send_element(VAL_MIN, 1'b1, pick_gap(0));
		// two-element blocks, swapped and already ordered
		send_element(VAL_MAX, 1'b0, pick_gap(0));
		send_element(VAL_MIN, 1'b1, pick_gap(0));
		send_element(VAL_MIN, 1'b0, pick_gap(0));
		send_element(VAL_MAX, 1'b1, pick_gap(0));
		// equal values must stay put
		send_element(32'sd5, 1'b0, 0);
		send_element(32'sd5, 1'b0, 0);
		send_element(-32'sd5, 1'b0, 0);
		send_element(32'sd5, 1'b1, pick_gap(0));
		// sign boundaries and alternating bit patterns in one block
		send_element(32'sd0, 1'b0, pick_gap(0));
		send_element(-32'sd1, 1'b0, pick_gap(0));
		send_element(VAL_MIN, 1'b0, pick_gap(0));
		send_element(VAL_MAX, 1'b0, pick_gap(0));
		send_element(32'sd1, 1'b0, pick_gap(0));
		send_element(32'sh5555_5555, 1'b0, pick_gap(0));
		send_element(32'shAAAA_AAAA, 1'b1, pick_gap(0));

		// let every directed result come out before the random part
		wait_drained();

		// random blocks: mostly short, a few medium, one that fills the store
		sent = 0;
		blk  = 0;
		while (sent < RANDOM_ITEMS) begin
			fill_block = (blk == 2);
			if (fill_block)
				size = SORT_DEPTH;
			else if ($urandom_range(0, 9) == 0)
				size = $urandom_range(9, 24);
			else
				size = $urandom_range(1, 8);
			burst = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < size; k++) begin
				// the full block closes on the store filling, not on last
				send_element(pick_value(), (k == size - 1) && !fill_block, pick_gap(burst));
				sent++;
			end
			if ($urandom_range(0, 7) == 0)
				wait_drained();
			blk++;
		end

		start <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && results_owed == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
